FILE: rtl/wls_pkg.sv
// Shared types and constants for the wave equation leapfrog stencil unit.
// Holds the transaction payload structs, action codes and datapath widths.
// No dependencies; all other files but wls_ram refer to it by scoped name.
package wls_pkg;

  // Largest grid: the nodes run 0 to MAX_INTERVALS.
  localparam int MAX_INTERVALS = 64;

  // Field and datapath widths.
  localparam int WORD_W     = 32;
  localparam int CFG_W      = 17;
  localparam int CFG_M_W    = 7;
  localparam int NODE_IDX_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 54;

  // Pipeline shape: two banks, three read taps per bank, four work stages.
  localparam int BANKS  = 2;
  localparam int TAPS   = 3;
  localparam int STAGES = 4;

  localparam int TAP_DN  = 0;
  localparam int TAP_MID = 1;
  localparam int TAP_UP  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COURANT_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU_SQ     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVALS  = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0]   COURANT_SQ_RST = 17'd65536;
  localparam logic [CFG_W-1:0]   TAU_SQ_RST     = 17'd655;
  localparam logic [CFG_M_W-1:0] INTERVALS_RST  = 7'd10;

  // Half of one Q8.24 step in the Q.40 accumulator, for round to nearest.
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 54'sh8000;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_LOAD_PREV = 2'd0,
    ACT_LOAD_CUR  = 2'd1,
    ACT_ADVANCE   = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef struct packed {
    action_t action;
    word_t   node_value;
    word_t   forcing;
  } in_item_t;

  typedef struct packed {
    logic [NODE_IDX_W-1:0] node_index;
    word_t                 new_value;
    logic                  last_of_layer;
  } out_item_t;

  // Register load strobes for the four work stages of the arithmetic.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_load_t;

  // Per-transaction control handed to the arithmetic at entry.
  typedef struct packed {
    logic compute;
    logic cur_sel;
  } entry_t;

endpackage

FILE: rtl/wave_equation_leapfrog_stencil_unit.sv
// Top level of the 1D wave equation leapfrog stencil unit.
// Depends on wls_pkg, wls_pipe, wls_arith and wls_ram.
//
// Usage: the host streams one grid node per input transaction on in_valid /
// in_ready. Load transactions fill the previous and the current layer, nodes
// 0..M in order; advance transactions return one output transaction each on
// out_valid / out_ready with the new node value. Node 0 and node M take the
// boundary value carried in node_value. After node M of an advance the layers
// swap roles. Configuration is written through cfg_write / cfg_index /
// cfg_data while no transaction is in flight.
// Throughput: one transaction per cycle unless held by the interlock or the
// receiver. From acceptance to out_valid: bank read, neighbor sum, products,
// partial sums, then the final sum, round and saturate into the output
// register. An interior advance whose neighbor words are still being written
// back waits at the input until the write-back stage drains; this occurs right
// after loading a current-layer node or, for very small M, next to a layer swap.
// Reset clears the node counter, the bank select and all valid bits; the
// banks are not cleared. When the receiver stalls, results back up through
// the pipeline and the input keeps accepting until all four stages are full.
module wave_equation_leapfrog_stencil_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wls_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wls_pkg::out_item_t            out_data,
  input  logic                          cfg_write,
  input  logic [wls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wls_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NODE_W = $clog2(wls_pkg::MAX_INTERVALS + 1);

  logic [wls_pkg::CFG_W-1:0]   courant_sq, tau_sq;
  logic [wls_pkg::CFG_M_W-1:0] intervals_in_use;

  wls_pkg::stage_load_t load;
  wls_pkg::entry_t      entry;
  wls_pkg::word_t       result;
  logic                 rd_en, wr_en, wr_bank;
  logic [NODE_W-1:0]    wr_addr;
  logic [wls_pkg::TAPS-1:0][NODE_W-1:0] rd_addr;
  wls_pkg::word_t [wls_pkg::BANKS-1:0][wls_pkg::TAPS-1:0] rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      courant_sq       <= wls_pkg::COURANT_SQ_RST;
      tau_sq           <= wls_pkg::TAU_SQ_RST;
      intervals_in_use <= wls_pkg::INTERVALS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        wls_pkg::CFG_COURANT_SQ: courant_sq       <= cfg_data;
        wls_pkg::CFG_TAU_SQ:     tau_sq           <= cfg_data;
        wls_pkg::CFG_INTERVALS:  intervals_in_use <= cfg_data[wls_pkg::CFG_M_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencing, interlock and output register.
  wls_pipe u_pipe (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (in_data.action),
    .intervals_in_use (intervals_in_use),
    .load             (load),
    .entry            (entry),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .wr_en            (wr_en),
    .wr_bank          (wr_bank),
    .wr_addr          (wr_addr),
    .result           (result),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_data)
  );

  // Stencil arithmetic.
  wls_arith u_arith (
    .clk        (clk),
    .load       (load),
    .entry      (entry),
    .node_value (in_data.node_value),
    .forcing    (in_data.forcing),
    .courant_sq (courant_sq),
    .tau_sq     (tau_sq),
    .rd_data    (rd_data),
    .result     (result)
  );

  // Two layer banks, each kept in one copy per read tap.
  for (genvar b = 0; b < wls_pkg::BANKS; b++) begin : g_bank
    for (genvar t = 0; t < wls_pkg::TAPS; t++) begin : g_tap
      wls_ram #(
        .WIDTH (wls_pkg::WORD_W),
        .DEPTH (wls_pkg::MAX_INTERVALS + 1)
      ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en && (wr_bank == 1'(b))),
        .wr_addr (wr_addr),
        .wr_data (result),
        .rd_en   (rd_en),
        .rd_addr (rd_addr[t]),
        .rd_data (rd_data[b][t])
      );
    end
  end

endmodule

FILE: rtl/wls_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for every copy of the two layer banks. No package dependency.
module wls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the output holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/wls_arith.sv
// Four-stage stencil math: entry, neighbor sum, products, partial sums; round/saturate.
// Depends on wls_pkg for widths, tap positions and the stage load strobes.
module wls_arith (
  input  logic                       clk,
  input  wls_pkg::stage_load_t       load,
  input  wls_pkg::entry_t            entry,
  input  wls_pkg::word_t             node_value,
  input  wls_pkg::word_t             forcing,
  input  logic [wls_pkg::CFG_W-1:0]  courant_sq,
  input  logic [wls_pkg::CFG_W-1:0]  tau_sq,
  input  wls_pkg::word_t [wls_pkg::BANKS-1:0][wls_pkg::TAPS-1:0] rd_data,
  output wls_pkg::word_t             result
);

  localparam int AW = wls_pkg::ACC_W;

  // Stage 1: entry control; the bank words sit in the RAM output registers.
  logic           cs1, comp1;
  wls_pkg::word_t val1, frc1;

  // Stage 2: neighbor sum and the center and previous-layer words.
  logic signed [wls_pkg::WORD_W:0] nb2;
  wls_pkg::word_t mid2, prv2, frc2, val2;
  logic           comp2;

  // Stage 3: products.
  logic signed [50:0] pa3, pb3;
  logic signed [49:0] pc3;
  wls_pkg::word_t     prv3, val3;
  logic               comp3;

  // Stage 4: two partial sums.
  logic signed [AW-1:0] ab4, cp4;
  wls_pkg::word_t       val4;
  logic                 comp4;

  // Center coefficient 2*(1-s) in Q.16, refreshed every cycle from the register.
  logic signed [17:0] one_minus_s;
  logic signed [18:0] center_coef;

  wls_pkg::word_t       c_dn, c_mid, c_up, p_mid;
  logic signed [50:0]   pa, pb;
  logic signed [49:0]   pc;
  logic signed [AW-1:0] ab, cp, total, scaled;
  logic                 fits;
  wls_pkg::word_t       sat;

  assign one_minus_s = 18'sd65536 - $signed({1'b0, courant_sq});

  always_ff @(posedge clk) begin
    center_coef <= {one_minus_s, 1'b0};
  end

  // Pick the current and previous layers out of the two banks.
  always_comb begin
    c_dn  = $signed(rd_data[cs1][wls_pkg::TAP_DN]);
    c_mid = $signed(rd_data[cs1][wls_pkg::TAP_MID]);
    c_up  = $signed(rd_data[cs1][wls_pkg::TAP_UP]);
    p_mid = $signed(rd_data[~cs1][wls_pkg::TAP_MID]);
  end

  // The three products of the stencil.
  assign pa = $signed({1'b0, courant_sq}) * nb2;
  assign pb = center_coef * mid2;
  assign pc = $signed({1'b0, tau_sq}) * frc2;

  // Partial sums; the rounding half step rides along with the source term.
  assign ab = AW'(pa3) + AW'(pb3);
  assign cp = AW'(pc3) - (AW'(prv3) <<< wls_pkg::FRAC_W) + wls_pkg::ROUND_HALF;

  // Final sum, drop to Q8.24 and clamp to the signed word range.
  always_comb begin
    total  = ab4 + cp4;
    scaled = total >>> wls_pkg::FRAC_W;
    fits   = (&scaled[AW-1:wls_pkg::WORD_W-1]) || !(|scaled[AW-1:wls_pkg::WORD_W-1]);
    if (fits) begin
      sat = scaled[wls_pkg::WORD_W-1:0];
    end else if (scaled[AW-1]) begin
      sat = {1'b1, {(wls_pkg::WORD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(wls_pkg::WORD_W-1){1'b1}}};
    end
    result = comp4 ? sat : val4;
  end

  // Stage registers, each loaded when its transaction moves in.
  always_ff @(posedge clk) begin
    if (load.s1) begin
      cs1   <= entry.cur_sel;
      comp1 <= entry.compute;
      val1  <= node_value;
      frc1  <= forcing;
    end
    if (load.s2) begin
      nb2   <= (wls_pkg::WORD_W + 1)'(c_up) + (wls_pkg::WORD_W + 1)'(c_dn);
      mid2  <= c_mid;
      prv2  <= p_mid;
      frc2  <= frc1;
      val2  <= val1;
      comp2 <= comp1;
    end
    if (load.s3) begin
      pa3   <= pa;
      pb3   <= pb;
      pc3   <= pc;
      prv3  <= prv2;
      val3  <= val2;
      comp3 <= comp2;
    end
    if (load.s4) begin
      ab4   <= ab;
      cp4   <= cp;
      val4  <= val3;
      comp4 <= comp3;
    end
  end

endmodule

FILE: rtl/wls_pipe.sv
// Pipeline control: node counter, bank select, stage valid bits, read-after-write
// interlock, bank read and write addressing, and the output register.
// Depends on wls_pkg for the action codes, payload structs and stage strobes.
module wls_pipe #(
  localparam int NODE_W = $clog2(wls_pkg::MAX_INTERVALS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wls_pkg::action_t                  action,
  input  logic [wls_pkg::CFG_M_W-1:0]       intervals_in_use,
  output wls_pkg::stage_load_t              load,
  output wls_pkg::entry_t                   entry,
  output logic                              rd_en,
  output logic [wls_pkg::TAPS-1:0][NODE_W-1:0] rd_addr,
  output logic                              wr_en,
  output logic                              wr_bank,
  output logic [NODE_W-1:0]                 wr_addr,
  input  wls_pkg::word_t                    result,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wls_pkg::out_item_t                out_item
);

  localparam int ST = wls_pkg::STAGES;

  logic [NODE_W-1:0] node_counter;
  logic              bank_select;

  logic [NODE_W-1:0] m_eff, p, p_next, tap_dn, tap_up;
  logic              last, interior, reads, enter, hazard, ready_first, out_free;
  logic              cur_phys, prev_phys, tgt_bank;

  logic [ST-1:0]             valid, adv_q, last_q, bank_q, mv, hit;
  logic [ST-1:0][NODE_W-1:0] addr_q;

  // Clamp the interval count to the supported range.
  always_comb begin
    if (intervals_in_use < 2) begin
      m_eff = NODE_W'(2);
    end else if (int'(intervals_in_use) > wls_pkg::MAX_INTERVALS) begin
      m_eff = NODE_W'(wls_pkg::MAX_INTERVALS);
    end else begin
      m_eff = NODE_W'(intervals_in_use);
    end
  end

  // Node addressed by the incoming transaction and its neighbors.
  always_comb begin
    p        = (node_counter > m_eff) ? '0 : node_counter;
    last     = (p == m_eff);
    p_next   = last ? '0 : p + NODE_W'(1);
    interior = (p != '0) && !last;
    tap_dn   = (p == '0) ? p : p - NODE_W'(1);
    tap_up   = last ? p : p + NODE_W'(1);
  end

  // Bank 0 holds the previous layer while bank_select is low.
  assign prev_phys = bank_select;
  assign cur_phys  = ~bank_select;

  always_comb begin
    case (action)
      wls_pkg::ACT_LOAD_CUR: tgt_bank = cur_phys;
      default:               tgt_bank = prev_phys;
    endcase
  end

  // Stage movement, from the output register back to the first stage.
  always_comb begin
    out_free   = !out_valid || out_ready;
    mv[ST-1]   = valid[ST-1] && (!adv_q[ST-1] || out_free);
    for (int k = ST - 2; k >= 0; k--) begin
      mv[k] = valid[k] && (!valid[k+1] || mv[k+1]);
    end
    ready_first = !valid[0] || mv[0];
  end

  // An interior advance waits while any bank word it reads is still to be written.
  always_comb begin
    reads = (action == wls_pkg::ACT_ADVANCE) && interior;
    for (int k = 0; k < ST; k++) begin
      hit[k] = valid[k] &&
               (((bank_q[k] == cur_phys) &&
                 ((addr_q[k] == tap_dn) || (addr_q[k] == p) || (addr_q[k] == tap_up))) ||
                ((bank_q[k] == prev_phys) && (addr_q[k] == p)));
    end
    hazard = reads && (|hit);
  end

  assign in_ready = ready_first && !hazard;
  assign enter    = in_valid && in_ready && (action != wls_pkg::ACT_NONE);

  // Bank reads are issued as a transaction enters.
  assign rd_en                    = enter;
  assign rd_addr[wls_pkg::TAP_DN]  = tap_dn;
  assign rd_addr[wls_pkg::TAP_MID] = p;
  assign rd_addr[wls_pkg::TAP_UP]  = tap_up;

  assign entry.compute = reads;
  assign entry.cur_sel = cur_phys;

  assign load.s1 = enter;
  assign load.s2 = mv[0];
  assign load.s3 = mv[1];
  assign load.s4 = mv[2];

  // Every transaction writes its bank word as it leaves the last stage.
  assign wr_en   = mv[ST-1];
  assign wr_bank = bank_q[ST-1];
  assign wr_addr = addr_q[ST-1];

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_counter <= '0;
      bank_select  <= 1'b0;
      valid        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (enter) begin
        node_counter <= p_next;
        if ((action == wls_pkg::ACT_ADVANCE) && last) begin
          bank_select <= ~bank_select;
        end
      end
      valid[0] <= enter || (valid[0] && !mv[0]);
      for (int k = 1; k < ST; k++) begin
        valid[k] <= mv[k-1] || (valid[k] && !mv[k]);
      end
      if (mv[ST-1] && adv_q[ST-1]) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage payload and the output register.
  always_ff @(posedge clk) begin
    if (enter) begin
      bank_q[0] <= tgt_bank;
      addr_q[0] <= p;
      adv_q[0]  <= (action == wls_pkg::ACT_ADVANCE);
      last_q[0] <= last;
    end
    for (int k = 1; k < ST; k++) begin
      if (mv[k-1]) begin
        bank_q[k] <= bank_q[k-1];
        addr_q[k] <= addr_q[k-1];
        adv_q[k]  <= adv_q[k-1];
        last_q[k] <= last_q[k-1];
      end
    end
    if (mv[ST-1] && adv_q[ST-1]) begin
      out_item.node_index    <= wls_pkg::NODE_IDX_W'(addr_q[ST-1]);
      out_item.new_value     <= result;
      out_item.last_of_layer <= last_q[ST-1];
    end
  end

endmodule

FILE: rtl/wls_checker.sv
// Port-level checks for the wave equation leapfrog stencil unit, and the bind
// that attaches them. Depends on wls_pkg and the top level's ports.
module wls_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input wls_pkg::out_item_t out_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A layer never closes before node 2.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_of_layer |-> out_data.node_index >= 2)
    else $error("layer closed at a node below the minimum interval count");

  // No node index lies beyond the largest grid.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(out_data.node_index) <= wls_pkg::MAX_INTERVALS)
    else $error("node index beyond the largest grid");

endmodule

bind wave_equation_leapfrog_stencil_unit wls_checker u_wls_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/tb_wave_equation_leapfrog_stencil_unit.sv
`timescale 1ns / 100ps
// Testbench for wave_equation_leapfrog_stencil_unit: streams load, advance and idle transactions,
// predicts every new node value with its own stencil model and checks each result.
// Depends on wls_pkg and the RTL of the block.
module tb_wave_equation_leapfrog_stencil_unit;

  localparam int SPAN_MAX     = wls_pkg::MAX_INTERVALS;
  localparam int NODES        = SPAN_MAX + 1;
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEM_TARGET  = 950;
  localparam int QUIET_TAIL   = 150;
  localparam longint ONE_Q16  = 65536;

  // Register index that the block does not implement; writes to it are dropped.
  localparam logic [wls_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam wls_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam wls_pkg::word_t WORD_MIN = 32'sh8000_0000;

  // Scoreboard: keeps its own copy of both layers, the bank roles, the node
  // pointer and the registers, and queues the node values each advance yields.
  class layer_scoreboard;
    wls_pkg::word_t              layer [2][NODES];
    bit                          prev_bank;
    int unsigned                 node_ptr;
    logic [wls_pkg::CFG_W-1:0]   courant;
    logic [wls_pkg::CFG_W-1:0]   tau;
    logic [wls_pkg::CFG_M_W-1:0] intervals;
    wls_pkg::out_item_t          pending_nodes [$];
    int unsigned                 errors;
    int unsigned                 checked;

    function new();
      prev_bank = 1'b0;
      node_ptr  = 0;
      courant   = wls_pkg::COURANT_SQ_RST;
      tau       = wls_pkg::TAU_SQ_RST;
      intervals = wls_pkg::INTERVALS_RST;
      errors    = 0;
      checked   = 0;
    endfunction

    // Number of intervals in force, clamped to what the banks can hold.
    function int unsigned span();
      if (intervals < 2) return 2;
      if (intervals > SPAN_MAX) return SPAN_MAX;
      return intervals;
    endfunction

    function void write_reg(logic [wls_pkg::CFG_IDX_W-1:0] idx,
                            logic [wls_pkg::CFG_W-1:0] data);
      case (idx)
        wls_pkg::CFG_COURANT_SQ: courant = data;
        wls_pkg::CFG_TAU_SQ:     tau = data;
        wls_pkg::CFG_INTERVALS:  intervals = data[wls_pkg::CFG_M_W-1:0];
        default: ;
      endcase
    endfunction

    // Leapfrog update of interior node i, exact in Q.40, then rounded half up
    // to Q8.24 and saturated.
    function wls_pkg::word_t stencil_value(int unsigned i, wls_pkg::word_t f);
      longint acc;
      longint q;
      bit     cur_bank;
      cur_bank = !prev_bank;
      acc = longint'(courant) *
            (longint'(layer[cur_bank][i+1]) + longint'(layer[cur_bank][i-1]));
      acc += 2 * (ONE_Q16 - longint'(courant)) * longint'(layer[cur_bank][i]);
      acc -= longint'(layer[prev_bank][i]) * ONE_Q16;
      acc += longint'(tau) * longint'(f);
      q = (acc + 32768) >>> 16;
      if (q > longint'(WORD_MAX)) q = longint'(WORD_MAX);
      if (q < longint'(WORD_MIN)) q = longint'(WORD_MIN);
      return wls_pkg::word_t'(q[31:0]);
    endfunction

    // Called for every accepted input transaction.
    function void note_transaction(wls_pkg::in_item_t it);
      int unsigned        m;
      int unsigned        i;
      bit                 at_end;
      wls_pkg::out_item_t node;
      if (it.action == wls_pkg::ACT_NONE) return;
      m = span();
      if (node_ptr > m) node_ptr = 0;
      i = node_ptr;
      at_end = (i == m);
      node_ptr = at_end ? 0 : i + 1;
      case (it.action)
        wls_pkg::ACT_LOAD_PREV: layer[prev_bank][i] = it.node_value;
        wls_pkg::ACT_LOAD_CUR:  layer[!prev_bank][i] = it.node_value;
        default: begin
          node.node_index    = wls_pkg::NODE_IDX_W'(i);
          node.new_value     = (i == 0 || at_end) ? it.node_value
                                                  : stencil_value(i, it.forcing);
          node.last_of_layer = at_end;
          layer[prev_bank][i] = node.new_value;
          if (at_end) prev_bank = !prev_bank;
          pending_nodes.push_back(node);
        end
      endcase
    endfunction

    function void flag(string field, logic [31:0] want_v, logic [31:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    endfunction

    // Called for every accepted output transaction.
    function void check_node(wls_pkg::out_item_t got);
      wls_pkg::out_item_t want;
      if (pending_nodes.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, node %0d value %h", $time,
                 got.node_index, got.new_value);
        return;
      end
      want = pending_nodes.pop_front();
      checked++;
      if (got.node_index !== want.node_index)
        flag("node_index", 32'(want.node_index), 32'(got.node_index));
      if (got.new_value !== want.new_value)
        flag("new_value", want.new_value, got.new_value);
      if (got.last_of_layer !== want.last_of_layer)
        flag("last_of_layer", 32'(want.last_of_layer), 32'(got.last_of_layer));
    endfunction
  endclass

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  wls_pkg::in_item_t             in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  wls_pkg::out_item_t            out_data;
  logic                          cfg_write = 1'b0;
  logic [wls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wls_pkg::CFG_W-1:0]     cfg_data = '0;

  layer_scoreboard scb = new();

  bit          quiet = 1'b0;
  int unsigned send_gap_odds = 0;
  int unsigned stall_odds = 0;
  int unsigned loads_sent = 0;
  int unsigned advances_sent = 0;
  int unsigned ignored_sent = 0;
  int unsigned phases = 0;

  wave_equation_leapfrog_stencil_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Timeout: the run did not finish in time.");
    $display("Test completed with failures");
    $finish;
  end

  // Sample both handshakes mid-cycle, then hand them to the scoreboard at the edge.
  initial begin : watch_handshakes
    bit                 in_fire;
    bit                 out_fire;
    wls_pkg::in_item_t  in_seen;
    wls_pkg::out_item_t out_seen;
    forever begin
      @(negedge clk);
      in_fire  = !rst && in_valid && in_ready;
      out_fire = !rst && out_valid && out_ready;
      in_seen  = in_data;
      out_seen = out_data;
      @(posedge clk);
      if (in_fire) scb.note_transaction(in_seen);
      if (out_fire) scb.check_node(out_seen);
    end
  end

  // Receiver: ready in random stretches, broken by stall bursts unless quiet.
  initial begin : drive_out_ready
    @(posedge clk);
    forever begin
      if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  function automatic wls_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3, 4: return wls_pkg::word_t'($urandom);
      default: return wls_pkg::word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [wls_pkg::CFG_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      3: return wls_pkg::CFG_W'($urandom_range(65537, 131071));
      default: return wls_pkg::CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [wls_pkg::CFG_M_W-1:0] pick_intervals();
    case ($urandom_range(0, 11))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return wls_pkg::CFG_M_W'($urandom_range(65, 127));
      5: return 7'd127;
      default: return wls_pkg::CFG_M_W'($urandom_range(2, 24));
    endcase
  endfunction

  // Register write; the enable drops in the following cycle, so writes never overlap.
  task automatic write_reg(input logic [wls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wls_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    scb.write_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // One input transaction, with an occasional gap before it.
  task automatic send_fields(input wls_pkg::action_t act, input wls_pkg::word_t value,
                             input wls_pkg::word_t force_v);
    wls_pkg::in_item_t it;
    bit                taken;
    it.action     = act;
    it.node_value = value;
    it.forcing    = force_v;
    if (!quiet && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    case (act)
      wls_pkg::ACT_LOAD_PREV, wls_pkg::ACT_LOAD_CUR: loads_sent++;
      wls_pkg::ACT_ADVANCE: advances_sent++;
      default: ignored_sent++;
    endcase
  endtask

  task automatic send_random(input wls_pkg::action_t act);
    send_fields(act, pick_word(), pick_word());
  endtask

  // Hold the input until every expected node has come back and the pipeline
  // has had time to finish any load write-back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scb.pending_nodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One phase: new settings, full reload of both layers, then a random mix of
  // advances with stray loads and ignored transactions.
  task automatic run_phase();
    int unsigned span_now;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    phases++;
    write_reg(wls_pkg::CFG_COURANT_SQ, pick_scale());
    write_reg(wls_pkg::CFG_TAU_SQ, pick_scale());
    write_reg(wls_pkg::CFG_INTERVALS, wls_pkg::CFG_W'(pick_intervals()));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, wls_pkg::CFG_W'($urandom));
    send_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
    stall_odds    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);

    // A reload of M+1 nodes covers every node whatever the pointer position.
    span_now = scb.span();
    for (k = 0; k <= span_now; k++) send_random(wls_pkg::ACT_LOAD_PREV);
    for (k = 0; k <= span_now; k++) send_random(wls_pkg::ACT_LOAD_CUR);

    n = $urandom_range(10, 120);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) send_random(wls_pkg::ACT_NONE);
      else if (pick < 10) send_random(wls_pkg::ACT_LOAD_PREV);
      else if (pick < 14) send_random(wls_pkg::ACT_LOAD_CUR);
      else send_random(wls_pkg::ACT_ADVANCE);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the smallest grid: extreme values, an ignored action,
    // saturation high and low, boundary nodes and a layer swap.
    write_reg(wls_pkg::CFG_INTERVALS, wls_pkg::CFG_W'(2));
    send_fields(wls_pkg::ACT_LOAD_PREV, WORD_MAX, '0);
    send_fields(wls_pkg::ACT_LOAD_PREV, WORD_MIN, WORD_MAX);
    send_fields(wls_pkg::ACT_LOAD_PREV, '0, WORD_MIN);
    send_fields(wls_pkg::ACT_NONE, WORD_MIN, WORD_MIN);
    send_fields(wls_pkg::ACT_LOAD_CUR, WORD_MAX, '0);
    send_fields(wls_pkg::ACT_LOAD_CUR, WORD_MIN, '0);
    send_fields(wls_pkg::ACT_LOAD_CUR, WORD_MAX, '0);
    send_fields(wls_pkg::ACT_ADVANCE, WORD_MIN, WORD_MAX);
    send_fields(wls_pkg::ACT_ADVANCE, '0, WORD_MAX);
    send_fields(wls_pkg::ACT_ADVANCE, WORD_MAX, WORD_MIN);
    wait_idle();
    write_reg(wls_pkg::CFG_COURANT_SQ, 17'h1FFFF);
    write_reg(wls_pkg::CFG_TAU_SQ, 17'd65536);
    send_fields(wls_pkg::ACT_ADVANCE, '0, WORD_MIN);
    send_fields(wls_pkg::ACT_ADVANCE, WORD_MAX, WORD_MIN);
    send_fields(wls_pkg::ACT_ADVANCE, WORD_MIN, '0);
    send_fields(wls_pkg::ACT_NONE, WORD_MAX, WORD_MAX);
    wait_idle();

    // Random phases; the tail of the run has no idling on either side.
    while (loads_sent + advances_sent < ITEM_TARGET) begin
      if (loads_sent + advances_sent > ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
      run_phase();
    end
    wait_idle();

    if (scb.pending_nodes.size() != 0) begin
      scb.errors++;
      $display("%0t: %0d expected results never arrived", $time, scb.pending_nodes.size());
    end
    $display("Summary: %0d loads, %0d advances and %0d ignored transactions over %0d phases.",
             loads_sent, advances_sent, ignored_sent, phases);
    $display("Summary: %0d results checked, %0d mismatches.", scb.checked, scb.errors);
    if (scb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/wls_pkg.sv
rtl/wls_ram.sv
rtl/wls_arith.sv
rtl/wls_pipe.sv
rtl/wave_equation_leapfrog_stencil_unit.sv
rtl/wls_checker.sv
tb/sv/tb_wave_equation_leapfrog_stencil_unit.sv
